@@ hdl/dqrk_pkg.sv @@
// Shared types and constants for the deque with remove by key.
`default_nettype none
package dqrk_pkg;

  // Default sizing
  localparam int unsigned DQRK_CAPACITY = 16;
  localparam int unsigned DQRK_KEY_BITS = 16;

  // Operation codes carried on in_kind
  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_BACK  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_REMOVE     = 2'd3
  } kind_t;

  // Result status codes carried on out_status
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic  en;
    kind_t kind;
  } cell_cmd_t;

endpackage
`default_nettype wire

@@ hdl/dqrk_cell.sv @@
// One slot of the key chain: holds a key and its valid flag, shifts with neighbours.
`default_nettype none
module dqrk_cell
  import dqrk_pkg::*;
#(
  parameter int unsigned KEY_BITS = DQRK_KEY_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cell_cmd_t           cmd,
  input  wire logic [KEY_BITS-1:0] in_key,
  input  wire logic [KEY_BITS-1:0] left_key,
  input  wire logic                left_valid,
  input  wire logic [KEY_BITS-1:0] right_key,
  input  wire logic                right_valid,
  input  wire logic                hit_in,
  input  wire logic [KEY_BITS-1:0] taken_in,
  output logic                     hit_out,
  output logic [KEY_BITS-1:0]      taken_out,
  output logic [KEY_BITS-1:0]      key_o,
  output logic                     valid_o
);

  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic                valid_r, valid_nxt;
  logic                match;

  // Key compare and first-match ripple along the chain
  assign match     = valid_r && (key_r == in_key);
  assign hit_out   = hit_in | match;
  assign taken_out = taken_in | ((match && !hit_in) ? key_r : '0);

  // Next slot contents per operation
  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    if (cmd.en) begin
      unique case (cmd.kind)
        KIND_PUSH_FRONT: begin
          key_nxt   = left_key;
          valid_nxt = left_valid;
        end
        KIND_PUSH_BACK: begin
          // first empty slot takes the key
          if (!valid_r && left_valid) begin
            key_nxt   = in_key;
            valid_nxt = 1'b1;
          end
        end
        KIND_POP_FRONT: begin
          key_nxt   = right_key;
          valid_nxt = right_valid;
        end
        KIND_REMOVE: begin
          // the matching slot and all behind it close the gap
          if (hit_out) begin
            key_nxt   = right_key;
            valid_nxt = right_valid;
          end
        end
        default: begin
          key_nxt   = key_r;
          valid_nxt = valid_r;
        end
      endcase
    end
  end

  // Key payload: no reset
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign key_o   = key_r;
  assign valid_o = valid_r;

endmodule
`default_nettype wire

@@ hdl/deque_with_remove_by_key.sv @@
// Deque with remove by key: a chain of CAPACITY key cells working in parallel.
// The result is registered in the cycle after the input transaction is accepted.
// One transaction per cycle if out_ready; the chain shifts, inserts and compares at once.
// Remove-by-key match search ripples through the cells within that cycle.
// Reset (rst_n low, synchronous): all cells empty, count zero, no result pending.
`default_nettype none
module deque_with_remove_by_key
  import dqrk_pkg::*;
#(
  parameter int unsigned CAPACITY = DQRK_CAPACITY,
  parameter int unsigned KEY_BITS = DQRK_KEY_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_kind,
  input  wire logic [KEY_BITS-1:0]           in_key,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_status,
  output logic [KEY_BITS-1:0]                out_taken_key,
  output logic [$clog2(CAPACITY+1)-1:0]      out_occupancy
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  kind_t                kind;
  logic                 accept;
  logic                 full, empty, found;
  cell_cmd_t            cmd;

  logic [KEY_BITS-1:0]  cell_key   [CAPACITY];
  logic                 cell_valid [CAPACITY];
  logic                 hit   [CAPACITY+1];
  logic [KEY_BITS-1:0]  taken [CAPACITY+1];

  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 out_valid_r;
  status_t              out_status_r, status_nxt;
  logic [KEY_BITS-1:0]  out_taken_key_r, taken_nxt;
  logic [CNT_W-1:0]     out_occupancy_r;

  assign kind     = kind_t'(in_kind);
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign empty    = (count_r == '0);
  assign found    = hit[CAPACITY];

  // Operation outcome, count update and chain enable
  always_comb begin
    status_nxt = ST_OK;
    taken_nxt  = '0;
    count_nxt  = count_r;
    cmd.kind   = kind;
    cmd.en     = 1'b0;
    unique case (kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.en    = accept;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          cmd.en    = accept;
          taken_nxt = cell_key[0];
          count_nxt = count_r - CNT_W'(1);
        end
      end
      KIND_REMOVE: begin
        if (found) begin
          cmd.en    = accept;
          taken_nxt = taken[CAPACITY];
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // Chain of cells, front at index zero
  assign hit[0]   = 1'b0;
  assign taken[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_BITS-1:0] lkey, rkey;
    logic                lvalid, rvalid;

    if (i == 0) begin : g_front
      assign lkey   = in_key;
      assign lvalid = 1'b1;
    end else begin : g_inner_l
      assign lkey   = cell_key[i-1];
      assign lvalid = cell_valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_back
      assign rkey   = '0;
      assign rvalid = 1'b0;
    end else begin : g_inner_r
      assign rkey   = cell_key[i+1];
      assign rvalid = cell_valid[i+1];
    end

    dqrk_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .in_key      (in_key),
      .left_key    (lkey),
      .left_valid  (lvalid),
      .right_key   (rkey),
      .right_valid (rvalid),
      .hit_in      (hit[i]),
      .taken_in    (taken[i]),
      .hit_out     (hit[i+1]),
      .taken_out   (taken[i+1]),
      .key_o       (cell_key[i]),
      .valid_o     (cell_valid[i])
    );
  end

  // Entry count and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r    <= status_nxt;
      out_taken_key_r <= taken_nxt;
      out_occupancy_r <= count_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_taken_key = out_taken_key_r;
  assign out_occupancy = out_occupancy_r;

endmodule
`default_nettype wire
